// ===== design/ps2kd_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2kd_pkg: shared types and constants for the set-1 key decoder
// Holds the command and register codes, the scancode byte values, the key
// offsets of the special codes and the two 58-entry character tables.
// ----------------------------------------------------------------------------
package ps2kd_pkg;

  // Widths fixed by the channel fields.
  localparam int CMD_W   = 2;
  localparam int SCAN_W  = 8;
  localparam int CODE_W  = 7;
  localparam int KEY_W   = 9;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  // Defaults for the top-level parameters.
  localparam int COUNT_BITS_DEF   = 16;
  localparam int SPECIAL_BASE_DEF = 256;

  // Input commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_SCAN  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPEAT_DELAY    = 1'b0,
    REG_REPEAT_INTERVAL = 1'b1
  } cfg_reg_t;

  // Configuration reset values and write minimums.
  localparam logic [CFG_W-1:0] REPEAT_DELAY_RST    = 16'd25;
  localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd3;
  localparam logic [CFG_W-1:0] REPEAT_DELAY_MIN    = 16'd5;
  localparam logic [CFG_W-1:0] REPEAT_INTERVAL_MIN = 16'd1;

  // Scancode bytes with a fixed role.
  localparam logic [SCAN_W-1:0] SC_PREFIX     = 8'hE0;
  localparam logic [SCAN_W-1:0] SC_LSHIFT_MK  = 8'h2A;
  localparam logic [SCAN_W-1:0] SC_RSHIFT_MK  = 8'h36;
  localparam logic [SCAN_W-1:0] SC_LSHIFT_BRK = 8'hAA;
  localparam logic [SCAN_W-1:0] SC_RSHIFT_BRK = 8'hB6;
  localparam logic [SCAN_W-1:0] SC_CTRL_MK    = 8'h1D;
  localparam logic [SCAN_W-1:0] SC_CTRL_BRK   = 8'h9D;
  localparam logic [SCAN_W-1:0] SC_ALT_MK     = 8'h38;
  localparam logic [SCAN_W-1:0] SC_ALT_BRK    = 8'hB8;

  // Make codes of the cursor, edit and function keys.
  localparam logic [CODE_W-1:0] MK_LEFT  = 7'h4B;
  localparam logic [CODE_W-1:0] MK_RIGHT = 7'h4D;
  localparam logic [CODE_W-1:0] MK_UP    = 7'h48;
  localparam logic [CODE_W-1:0] MK_DOWN  = 7'h50;
  localparam logic [CODE_W-1:0] MK_HOME  = 7'h47;
  localparam logic [CODE_W-1:0] MK_END   = 7'h4F;
  localparam logic [CODE_W-1:0] MK_DEL   = 7'h53;
  localparam logic [CODE_W-1:0] MK_TAB   = 7'h0F;
  localparam logic [CODE_W-1:0] MK_F4    = 7'h3E;

  // Offsets of the special key codes above the special base.
  localparam int KEY_OFS_LEFT  = 0;
  localparam int KEY_OFS_RIGHT = 1;
  localparam int KEY_OFS_UP    = 2;
  localparam int KEY_OFS_DOWN  = 3;
  localparam int KEY_OFS_HOME  = 4;
  localparam int KEY_OFS_END   = 5;
  localparam int KEY_OFS_DEL   = 6;
  localparam int KEY_OFS_TAB   = 7;
  localparam int KEY_OFS_F4    = 8;

  // Printable ASCII range that repeats, and the letter ranges for ctrl.
  localparam logic [KEY_W-1:0] ASCII_PRINT_LO = 9'h020;
  localparam logic [KEY_W-1:0] ASCII_DEL      = 9'h07F;
  localparam logic [7:0] ASCII_LC_A = 8'h61;
  localparam logic [7:0] ASCII_LC_Z = 8'h7A;
  localparam logic [7:0] ASCII_UC_A = 8'h41;
  localparam logic [7:0] ASCII_UC_Z = 8'h5A;
  localparam logic [7:0] CTRL_LC_OFS = 8'h60;
  localparam logic [7:0] CTRL_UC_OFS = 8'h40;

  // Character tables, indexed by make code.
  localparam int TABLE_LEN = 58;
  localparam int TABLE_IDX_W = $clog2(TABLE_LEN);

  localparam logic [7:0] PLAIN_MAP [TABLE_LEN] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  localparam logic [7:0] UPPER_MAP [TABLE_LEN] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  // Modifier flags.
  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
  } mods_t;

  // One result item.
  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    logic             is_repeat;
    mods_t            mods;
  } res_t;

endpackage

// ===== design/ps2kd_keymap.sv =====
// ----------------------------------------------------------------------------
// ps2kd_keymap: make code to key code translation
// Maps a 7-bit make code with its extended flag and the modifier state to a
// key code; zero means the code is not mapped.
// ----------------------------------------------------------------------------
module ps2kd_keymap
  import ps2kd_pkg::*;
#(
  parameter int SPECIAL_BASE = SPECIAL_BASE_DEF
) (
  input  logic [CODE_W-1:0] code,
  input  logic              ext,
  input  mods_t             mods,
  output logic [KEY_W-1:0]  key
);

  localparam logic [KEY_W-1:0] BASE = KEY_W'(SPECIAL_BASE);

  logic [7:0] table_char;
  logic [7:0] char_mod;

  // Table lookup with the ctrl letter mapping on top.
  always_comb begin
    table_char = 8'h00;
    if (code < CODE_W'(TABLE_LEN)) begin
      table_char = mods.shift ? UPPER_MAP[code[TABLE_IDX_W-1:0]]
                              : PLAIN_MAP[code[TABLE_IDX_W-1:0]];
    end
    char_mod = table_char;
    if (mods.ctrl && table_char >= ASCII_LC_A && table_char <= ASCII_LC_Z) begin
      char_mod = table_char - CTRL_LC_OFS;
    end else if (mods.ctrl && table_char >= ASCII_UC_A && table_char <= ASCII_UC_Z) begin
      char_mod = table_char - CTRL_UC_OFS;
    end
  end

  // Extended codes know only the cursor and edit block; plain codes map tab, F4
  // and that block without up and down ahead of the character tables.
  always_comb begin
    key = '0;
    if (ext) begin
      case (code)
        MK_LEFT:  key = BASE + KEY_W'(KEY_OFS_LEFT);
        MK_RIGHT: key = BASE + KEY_W'(KEY_OFS_RIGHT);
        MK_UP:    key = BASE + KEY_W'(KEY_OFS_UP);
        MK_DOWN:  key = BASE + KEY_W'(KEY_OFS_DOWN);
        MK_HOME:  key = BASE + KEY_W'(KEY_OFS_HOME);
        MK_END:   key = BASE + KEY_W'(KEY_OFS_END);
        MK_DEL:   key = BASE + KEY_W'(KEY_OFS_DEL);
        default:  key = '0;
      endcase
    end else begin
      case (code)
        MK_TAB:   key = BASE + KEY_W'(KEY_OFS_TAB);
        MK_F4:    key = BASE + KEY_W'(KEY_OFS_F4);
        MK_LEFT:  key = BASE + KEY_W'(KEY_OFS_LEFT);
        MK_RIGHT: key = BASE + KEY_W'(KEY_OFS_RIGHT);
        MK_HOME:  key = BASE + KEY_W'(KEY_OFS_HOME);
        MK_END:   key = BASE + KEY_W'(KEY_OFS_END);
        MK_DEL:   key = BASE + KEY_W'(KEY_OFS_DEL);
        default:  key = KEY_W'(char_mod);
      endcase
    end
  end

endmodule

// ===== design/ps2kd_core.sv =====
// ----------------------------------------------------------------------------
// ps2kd_core: key state, typematic countdown and result register
// Processes one registered item per cycle unless a stalled result holds it;
// updates the modifier, prefix, held key and repeat state, loads sent keys.
// ----------------------------------------------------------------------------
module ps2kd_core
  import ps2kd_pkg::*;
#(
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  parameter int SPECIAL_BASE = SPECIAL_BASE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [SCAN_W-1:0] scan,
  input  logic [CFG_W-1:0]  delay,
  input  logic [CFG_W-1:0]  interval,
  input  logic              res_stall,
  output logic              res_valid,
  output res_t              res
);

  localparam int WIDE_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam logic [WIDE_W-1:0] COUNT_MAX = WIDE_W'({COUNT_BITS{1'b1}});
  localparam logic [KEY_W-1:0] SPC_LO  = KEY_W'(SPECIAL_BASE);
  localparam logic [KEY_W-1:0] SPC_DEL = KEY_W'(SPECIAL_BASE + KEY_OFS_DEL);

  // Key state.
  mods_t                 mods_r, mods_nxt;
  logic                  prefix_r, prefix_nxt;
  logic [KEY_W-1:0]      held_r, held_nxt;
  logic [KEY_W-1:0]      rpt_code_r, rpt_code_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  // Result register.
  logic                  res_valid_r, res_valid_nxt;
  res_t                  res_r, res_nxt;

  logic [KEY_W-1:0]      key;
  logic [KEY_W-1:0]      scan_id;
  logic                  key_rpt;
  logic                  send;
  logic [COUNT_BITS-1:0] delay_load;
  logic [COUNT_BITS-1:0] interval_load;
  logic [WIDE_W-1:0]     delay_wide;
  logic [WIDE_W-1:0]     interval_wide;

  ps2kd_keymap #(
    .SPECIAL_BASE (SPECIAL_BASE)
  ) u_keymap (
    .code (scan[CODE_W-1:0]),
    .ext  (prefix_r),
    .mods (mods_r),
    .key  (key)
  );

  // Countdown loads saturate at the largest count the counter holds.
  always_comb begin
    delay_wide    = WIDE_W'(delay);
    interval_wide = WIDE_W'(interval);
    delay_load    = (delay_wide > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                             : delay_wide[COUNT_BITS-1:0];
    interval_load = (interval_wide > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                                : interval_wide[COUNT_BITS-1:0];
  end

  // Held key id: extended flag in the top bit, make code in the low bits.
  assign scan_id = {prefix_r, 1'b0, scan[CODE_W-1:0]};
  assign key_rpt = (key >= SPC_LO && key <= SPC_DEL) ||
                   (key >= ASCII_PRINT_LO && key < ASCII_DEL);

  // Next state of the key tracking and the result to send.
  always_comb begin
    mods_nxt     = mods_r;
    prefix_nxt   = prefix_r;
    held_nxt     = held_r;
    rpt_code_nxt = rpt_code_r;
    cnt_nxt      = cnt_r;
    send         = 1'b0;
    res_nxt      = res_r;
    if (step) begin
      case (cmd)
        CMD_CLEAR: begin
          rpt_code_nxt = '0;
          cnt_nxt      = '0;
        end
        CMD_TICK: begin
          if (rpt_code_r != '0) begin
            if (cnt_r > COUNT_BITS'(1)) begin
              cnt_nxt = cnt_r - COUNT_BITS'(1);
            end else begin
              cnt_nxt           = interval_load;
              send              = 1'b1;
              res_nxt.key_code  = rpt_code_r;
              res_nxt.is_repeat = 1'b1;
              res_nxt.mods      = mods_r;
            end
          end
        end
        CMD_SCAN: begin
          case (scan)
            SC_PREFIX: begin
              prefix_nxt = 1'b1;
            end
            SC_LSHIFT_MK, SC_RSHIFT_MK: begin
              mods_nxt.shift = 1'b1;
              prefix_nxt     = 1'b0;
            end
            SC_LSHIFT_BRK, SC_RSHIFT_BRK: begin
              mods_nxt.shift = 1'b0;
              prefix_nxt     = 1'b0;
            end
            SC_CTRL_MK: begin
              mods_nxt.ctrl = 1'b1;
              prefix_nxt    = 1'b0;
            end
            SC_CTRL_BRK: begin
              mods_nxt.ctrl = 1'b0;
              prefix_nxt    = 1'b0;
            end
            SC_ALT_MK: begin
              mods_nxt.alt = 1'b1;
              prefix_nxt   = 1'b0;
            end
            SC_ALT_BRK: begin
              mods_nxt.alt = 1'b0;
              prefix_nxt   = 1'b0;
            end
            default: begin
              prefix_nxt = 1'b0;
              if (scan[SCAN_W-1]) begin
                // Break code: drop the held key if it matches, and stop the repeat if the key is mapped.
                if (held_r == scan_id) begin
                  held_nxt = '0;
                end
                if (key != '0) begin
                  rpt_code_nxt = '0;
                  cnt_nxt      = '0;
                end
              end else if (held_r != scan_id) begin
                // New make code: send it if it is mapped and arm the repeat if it repeats.
                held_nxt = scan_id;
                if (key != '0) begin
                  if (key_rpt) begin
                    rpt_code_nxt = key;
                    cnt_nxt      = delay_load;
                  end
                  send              = 1'b1;
                  res_nxt.key_code  = key;
                  res_nxt.is_repeat = 1'b0;
                  res_nxt.mods      = mods_r;
                end
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // The result register empties when taken and refills on a send.
  always_comb begin
    res_valid_nxt = res_valid_r;
    if (send) begin
      res_valid_nxt = 1'b1;
    end else if (!res_stall) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r      <= '0;
      prefix_r    <= 1'b0;
      held_r      <= '0;
      rpt_code_r  <= '0;
      cnt_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      mods_r      <= mods_nxt;
      prefix_r    <= prefix_nxt;
      held_r      <= held_nxt;
      rpt_code_r  <= rpt_code_nxt;
      cnt_r       <= cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  // An armed repeat always has a countdown still running.
  a_armed_count: assert property (@(posedge clk) disable iff (!rst_n)
    (rpt_code_r != '0) |-> (cnt_r != '0))
    else $error("repeat armed with an empty countdown");

  // A clear command leaves no repeat armed.
  a_clear_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (step && cmd == CMD_CLEAR) |=> (rpt_code_r == '0))
    else $error("repeat still armed after clear");

  // Only a tick can produce a repeated key.
  a_repeat_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (send && cmd != CMD_TICK) |=> !res_r.is_repeat)
    else $error("repeat flag set on a scancode result");

  // A key that is sent is never the unmapped code.
  a_key_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> (res_r.key_code != '0))
    else $error("result with an unmapped key code");

endmodule

// ===== design/ps2_set1_key_decoder_autorepeat.sv =====
// ----------------------------------------------------------------------------
// ps2_set1_key_decoder_autorepeat: set-1 scancode decoder with typematic
// Decodes set-1 scancode bytes into key codes with modifier flags and
// repeats the last repeatable key on timer ticks.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+--------------------------------
//   in_     | input     | in_valid/in_stall  | command, scan_byte
//   out_    | output    | out_valid/out_stall| key_code, is_repeat, modifiers
//   cfg_    | input     | cfg_valid/cfg_ready| index, data (always ready)
//
// One item per cycle is accepted while in_stall is low; the input register is
// loaded when the transfer is taken and the result register when the item
// then steps through the core, so a stalled result can hold it in between.
// The throughput is set by the single state update that every item goes
// through, one item per cycle while no stalled result holds it.
// Synchronous active-low reset clears the key state and loads the register
// defaults. in_stall rises only when the input register is full and the
// result register holds a stalled result.
// ----------------------------------------------------------------------------
module ps2_set1_key_decoder_autorepeat
  import ps2kd_pkg::*;
#(
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  parameter int SPECIAL_BASE = SPECIAL_BASE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [SCAN_W-1:0]    in_scan_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KEY_W-1:0]     out_key_code,
  output logic                 out_is_repeat,
  output logic                 out_shift_held,
  output logic                 out_ctrl_held,
  output logic                 out_alt_held,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Input register.
  logic              item_vld_r, item_vld_nxt;
  logic [CMD_W-1:0]  item_cmd_r;
  logic [SCAN_W-1:0] item_scan_r;

  // Configuration registers.
  logic [CFG_W-1:0]  delay_r, delay_nxt;
  logic [CFG_W-1:0]  interval_r, interval_nxt;

  logic              in_take;
  logic              step;
  logic              res_valid;
  res_t              res;

  // The registered item moves on unless a stalled result blocks it.
  assign step     = item_vld_r && !(res_valid && out_stall);
  assign in_stall = item_vld_r && res_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_take) begin
      item_vld_nxt = 1'b1;
    end else if (step) begin
      item_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_cmd_r  <= in_command;
      item_scan_r <= in_scan_byte;
    end
  end

  // Register writes saturate at the minimums.
  assign cfg_ready = 1'b1;

  always_comb begin
    delay_nxt    = delay_r;
    interval_nxt = interval_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REPEAT_DELAY: begin
          delay_nxt = (cfg_data < REPEAT_DELAY_MIN) ? REPEAT_DELAY_MIN : cfg_data;
        end
        REG_REPEAT_INTERVAL: begin
          interval_nxt = (cfg_data < REPEAT_INTERVAL_MIN) ? REPEAT_INTERVAL_MIN
                                                           : cfg_data;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r    <= REPEAT_DELAY_RST;
      interval_r <= REPEAT_INTERVAL_RST;
    end else begin
      delay_r    <= delay_nxt;
      interval_r <= interval_nxt;
    end
  end

  ps2kd_core #(
    .COUNT_BITS   (COUNT_BITS),
    .SPECIAL_BASE (SPECIAL_BASE)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cmd       (item_cmd_r),
    .scan      (item_scan_r),
    .delay     (delay_r),
    .interval  (interval_r),
    .res_stall (out_stall),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result fields.
  assign out_valid      = res_valid;
  assign out_key_code   = res.key_code;
  assign out_is_repeat  = res.is_repeat;
  assign out_shift_held = res.mods.shift;
  assign out_ctrl_held  = res.mods.ctrl;
  assign out_alt_held   = res.mods.alt;

endmodule

// ===== tb/ps2_set1_key_decoder_autorepeat_test.sv =====
// ----------------------------------------------------------------------------
// ps2_set1_key_decoder_autorepeat_test: self-checking bench for the decoder
// Sends scancode bytes, timer ticks and clear commands through the input
// channel and predicts every key event, including modifier flags and
// typematic repeats. A short directed part comes first, then random key
// sequences over several repeat settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module ps2_set1_key_decoder_autorepeat_test;
  import ps2kd_pkg::*;

  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          IDLE_PERCENT  = 9;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [7:0]  BREAK_BIT     = 8'h80;
  localparam int          KEY_BASE      = SPECIAL_BASE_DEF;
  localparam logic [31:0] COUNT_MAX     = 32'((64'd1 << COUNT_BITS_DEF) - 64'd1);

  localparam logic [7:0] MOD_MAKE  [4] = '{SC_LSHIFT_MK, SC_RSHIFT_MK, SC_CTRL_MK, SC_ALT_MK};
  localparam logic [7:0] MOD_BREAK [4] = '{SC_LSHIFT_BRK, SC_RSHIFT_BRK, SC_CTRL_BRK, SC_ALT_BRK};
  localparam logic [CODE_W-1:0] EXT_KEYS [7] = '{MK_LEFT, MK_RIGHT, MK_UP, MK_DOWN,
                                                 MK_HOME, MK_END, MK_DEL};

  // Predicts key events and holds the ones still to come from the block.
  class keystroke_board;
    logic [CFG_W-1:0]  delay, interval;
    bit                shift, ctrl, alt, prefix;
    logic [KEY_W-1:0]  held_id, armed_key;
    logic [CFG_W-1:0]  countdown;
    res_t              pending_keys[$];
    int                errors;

    function new();
      delay      = REPEAT_DELAY_RST;
      interval   = REPEAT_INTERVAL_RST;
      shift      = 0;
      ctrl       = 0;
      alt        = 0;
      prefix     = 0;
      held_id    = '0;
      armed_key  = '0;
      countdown  = '0;
      errors     = 0;
    endfunction

    function int pending();
      return pending_keys.size();
    endfunction

    // Register writes saturate at the minimums.
    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
      if (idx == REG_REPEAT_DELAY)
        delay = (value < REPEAT_DELAY_MIN) ? REPEAT_DELAY_MIN : value;
      else
        interval = (value < REPEAT_INTERVAL_MIN) ? REPEAT_INTERVAL_MIN : value;
    endfunction

    // The countdown holds at most COUNT_BITS bits.
    function logic [CFG_W-1:0] count_value(logic [CFG_W-1:0] v);
      return (32'(v) > COUNT_MAX) ? CFG_W'(COUNT_MAX) : v;
    endfunction

    // Key code of a make code under the current modifiers, zero if unmapped.
    function logic [KEY_W-1:0] key_of(logic [CODE_W-1:0] code, bit ext);
      logic [7:0] ch;
      if (ext) begin
        case (code)
          MK_LEFT:  return KEY_W'(KEY_BASE + KEY_OFS_LEFT);
          MK_RIGHT: return KEY_W'(KEY_BASE + KEY_OFS_RIGHT);
          MK_UP:    return KEY_W'(KEY_BASE + KEY_OFS_UP);
          MK_DOWN:  return KEY_W'(KEY_BASE + KEY_OFS_DOWN);
          MK_HOME:  return KEY_W'(KEY_BASE + KEY_OFS_HOME);
          MK_END:   return KEY_W'(KEY_BASE + KEY_OFS_END);
          MK_DEL:   return KEY_W'(KEY_BASE + KEY_OFS_DEL);
          default:  return '0;
        endcase
      end
      case (code)
        MK_TAB:   return KEY_W'(KEY_BASE + KEY_OFS_TAB);
        MK_F4:    return KEY_W'(KEY_BASE + KEY_OFS_F4);
        MK_LEFT:  return KEY_W'(KEY_BASE + KEY_OFS_LEFT);
        MK_RIGHT: return KEY_W'(KEY_BASE + KEY_OFS_RIGHT);
        MK_HOME:  return KEY_W'(KEY_BASE + KEY_OFS_HOME);
        MK_END:   return KEY_W'(KEY_BASE + KEY_OFS_END);
        MK_DEL:   return KEY_W'(KEY_BASE + KEY_OFS_DEL);
        default: ;
      endcase
      if (code >= TABLE_LEN) return '0;
      ch = shift ? UPPER_MAP[code] : PLAIN_MAP[code];
      // With ctrl held, letters of either case become 1..26.
      if (ctrl && ch >= ASCII_LC_A && ch <= ASCII_LC_Z) ch = ch - CTRL_LC_OFS;
      else if (ctrl && ch >= ASCII_UC_A && ch <= ASCII_UC_Z) ch = ch - CTRL_UC_OFS;
      return {1'b0, ch};
    endfunction

    function bit repeats(logic [KEY_W-1:0] k);
      if (k >= KEY_W'(KEY_BASE + KEY_OFS_LEFT) && k <= KEY_W'(KEY_BASE + KEY_OFS_DEL))
        return 1;
      return k >= ASCII_PRINT_LO && k < ASCII_DEL;
    endfunction

    function void queue_event(logic [KEY_W-1:0] k, bit rep);
      pending_keys.push_back({k, rep, shift, ctrl, alt});
    endfunction

    // Updates the key state for one accepted transfer.
    function void accept_item(logic [CMD_W-1:0] cmd, logic [SCAN_W-1:0] sc);
      logic [CODE_W-1:0] code;
      logic [KEY_W-1:0]  id, k;
      bit                ext;
      case (cmd)
        CMD_CLEAR: begin
          armed_key  = '0;
          countdown  = '0;
        end
        CMD_TICK: begin
          if (armed_key == '0) return;
          if (countdown > 1) begin
            countdown = countdown - 1'b1;
            return;
          end
          countdown = count_value(interval);
          queue_event(armed_key, 1'b1);
        end
        CMD_SCAN: begin
          case (sc)
            SC_PREFIX: begin
              prefix = 1;
              return;
            end
            SC_LSHIFT_MK, SC_RSHIFT_MK: begin
              shift  = 1;
              prefix = 0;
              return;
            end
            SC_LSHIFT_BRK, SC_RSHIFT_BRK: begin
              shift  = 0;
              prefix = 0;
              return;
            end
            SC_CTRL_MK: begin
              ctrl   = 1;
              prefix = 0;
              return;
            end
            SC_CTRL_BRK: begin
              ctrl   = 0;
              prefix = 0;
              return;
            end
            SC_ALT_MK: begin
              alt    = 1;
              prefix = 0;
              return;
            end
            SC_ALT_BRK: begin
              alt    = 0;
              prefix = 0;
              return;
            end
            default: ;
          endcase
          code   = sc[CODE_W-1:0];
          ext    = prefix;
          prefix = 0;
          id     = {ext, 1'b0, code};
          // A release of any mapped key stops the repeat.
          if (sc[SCAN_W-1]) begin
            if (held_id == id) held_id = '0;
            if (key_of(code, ext) != '0) begin
              armed_key  = '0;
              countdown  = '0;
            end
            return;
          end
          if (held_id == id) return;
          held_id = id;
          k = key_of(code, ext);
          if (k == '0) return;
          if (repeats(k)) begin
            armed_key  = k;
            countdown  = count_value(delay);
          end
          queue_event(k, 1'b0);
        end
        default: ;
      endcase
    endfunction

    // Compares one result transfer with the oldest expected key event.
    function void match_key(res_t act);
      res_t want;
      if (pending_keys.size() == 0) begin
        $display("%0t unexpected result: expected none, actual key %0d rep %0b mods %b",
                 $time, act.key_code, act.is_repeat, act.mods);
        errors++;
        return;
      end
      want = pending_keys.pop_front();
      if (act.key_code !== want.key_code) begin
        $display("%0t key_code mismatch: expected %0d, actual %0d",
                 $time, want.key_code, act.key_code);
        errors++;
      end
      if (act.is_repeat !== want.is_repeat) begin
        $display("%0t is_repeat mismatch: expected %0b, actual %0b",
                 $time, want.is_repeat, act.is_repeat);
        errors++;
      end
      if (act.mods.shift !== want.mods.shift) begin
        $display("%0t shift_held mismatch: expected %0b, actual %0b",
                 $time, want.mods.shift, act.mods.shift);
        errors++;
      end
      if (act.mods.ctrl !== want.mods.ctrl) begin
        $display("%0t ctrl_held mismatch: expected %0b, actual %0b",
                 $time, want.mods.ctrl, act.mods.ctrl);
        errors++;
      end
      if (act.mods.alt !== want.mods.alt) begin
        $display("%0t alt_held mismatch: expected %0b, actual %0b",
                 $time, want.mods.alt, act.mods.alt);
        errors++;
      end
    endfunction
  endclass

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_command   = CMD_SCAN;
  logic [SCAN_W-1:0]    in_scan_byte = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [KEY_W-1:0]     out_key_code;
  logic                 out_is_repeat;
  logic                 out_shift_held;
  logic                 out_ctrl_held;
  logic                 out_alt_held;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;

  keystroke_board board;
  bit             idle_on = 1;
  int             sent    = 0;
  int             cycles  = 0;

  ps2_set1_key_decoder_autorepeat u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_scan_byte   (in_scan_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_code   (out_key_code),
    .out_is_repeat  (out_is_repeat),
    .out_shift_held (out_shift_held),
    .out_ctrl_held  (out_ctrl_held),
    .out_alt_held   (out_alt_held),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Clock generation.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Random receiver stall.
  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.match_key({out_key_code, out_is_repeat, out_shift_held, out_ctrl_held,
                       out_alt_held});
  end

  // Run timeout.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sends one input transfer, with random idle cycles ahead of it.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [SCAN_W-1:0] sc);
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_scan_byte <= sc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.accept_item(cmd, sc);
    if (cmd != CMD_UNUSED) sent++;
  endtask

  task automatic scan(logic [SCAN_W-1:0] sc);
    send_item(CMD_SCAN, sc);
  endtask

  task automatic tick();
    send_item(CMD_TICK, SCAN_W'($urandom_range(255)));
  endtask

  // Holds the sender until every expected key event has arrived.
  task automatic hold_until_empty();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Lets the block run dry before a register write.
  task automatic settle();
    hold_until_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, value);
  endtask

  task automatic set_repeat(logic [CFG_W-1:0] delay, logic [CFG_W-1:0] interval);
    settle();
    cfg_write(REG_REPEAT_DELAY, delay);
    cfg_write(REG_REPEAT_INTERVAL, interval);
    cfg_valid <= 1'b0;
  endtask

  // One typing gesture: optional modifier, press, ticks or clears, optional release.
  task automatic key_gesture();
    logic [SCAN_W-1:0] mk;
    bit                ext;
    int                mod, ticks, span;
    mod = ($urandom_range(3) == 0) ? $urandom_range(3) : -1;
    if (mod >= 0) scan(MOD_MAKE[mod]);
    ext = ($urandom_range(3) == 0);
    if ($urandom_range(9) == 0) mk = SCAN_W'($urandom_range(127));
    else if (ext) mk = {1'b0, EXT_KEYS[$urandom_range(6)]};
    else mk = SCAN_W'($urandom_range(1, TABLE_LEN - 1));
    if (ext) scan(SC_PREFIX);
    scan(mk);
    span  = board.delay + 2 * board.interval;
    ticks = $urandom_range(0, (span > 40) ? 40 : span);
    repeat (ticks) begin
      if ($urandom_range(19) == 0) send_item(CMD_CLEAR, SCAN_W'($urandom_range(255)));
      else tick();
    end
    if ($urandom_range(4) != 0) begin
      if (ext) scan(SC_PREFIX);
      scan(mk | BREAK_BIT);
    end
    if (mod >= 0 && $urandom_range(9) < 7) scan(MOD_BREAK[mod]);
  endtask

  // Mostly well-formed gestures, the rest raw noise on every command.
  task automatic random_burst(int n);
    int target;
    target = sent + n;
    while (sent < target) begin
      if ($urandom_range(99) < 75) key_gesture();
      else send_item(CMD_W'($urandom_range(3)), SCAN_W'($urandom_range(255)));
    end
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings.
    send_item(CMD_UNUSED, 8'hFF);        // unused command is ignored
    tick();                              // no repeat armed yet
    scan(8'h00);                         // make code 00 matches the idle held id
    scan(8'h1E);                         // 'a', arms the repeat
    scan(8'h1E);                         // already held
    scan(SC_LSHIFT_MK);
    scan(8'h9E);                         // release of 'a' stops the repeat
    scan(8'h10);                         // 'Q'
    scan(SC_CTRL_MK);
    scan(8'h11);                         // ctrl+W, not repeatable
    scan(SC_CTRL_BRK);
    scan(SC_RSHIFT_BRK);
    scan(SC_ALT_MK);
    scan(8'h39);                         // space with alt
    scan(SC_ALT_BRK);
    scan(SC_PREFIX);
    scan({1'b0, MK_UP});                 // extended up
    scan(SC_PREFIX);
    scan(SC_LSHIFT_BRK);                 // modifier drops the prefix
    scan({1'b0, MK_UP});                 // plain 48 is unmapped
    scan({1'b0, MK_TAB});
    scan({1'b0, MK_F4});
    scan(8'h7F);                         // unmapped make code
    scan(SC_PREFIX);
    scan({1'b0, MK_DEL});
    scan(8'hFF);                         // release of an unmapped key
    send_item(CMD_CLEAR, 8'h00);
    tick();

    // Writes below the minimums, then a repeat run at the fastest rate.
    set_repeat(16'h0000, 16'h0000);
    scan(8'h25);                         // 'k'
    repeat (8) tick();
    scan(8'hA5);
    tick();

    // Random part over several settings.
    set_repeat(CFG_W'($urandom_range(5, 12)), CFG_W'($urandom_range(1, 4)));
    random_burst(300);
    set_repeat(REPEAT_DELAY_RST, REPEAT_INTERVAL_RST);
    random_burst(150);
    hold_until_empty();
    random_burst(150);
    set_repeat(CFG_W'($urandom_range(5, 10)), CFG_W'($urandom_range(1, 3)));
    idle_on = 0;
    random_burst(300);
    idle_on = 1;
    set_repeat(16'hFFFF, 16'hFFFF);
    random_burst(150);
    set_repeat(16'h0004, 16'h0002);
    random_burst(300);
    set_repeat(CFG_W'($urandom_range(5, 20)), CFG_W'($urandom_range(1, 6)));
    random_burst(350);

    settle();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
